// ===== rtl/core/mipp_pkg.sv =====
package mipp_pkg;

	// length field limits
	localparam int MAX_LENGTH_GROUPS = 4;
	localparam int GROUP_CNT_W       = 3;
	localparam int LEN_W             = 28;
	localparam int TLEN_W            = 16;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] TYPE_CONNACK = 4'd2;
	localparam logic [3:0] TYPE_PUBLISH = 4'd3;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_TLEN_HI = 3'd2,
		PH_TLEN_LO = 3'd3,
		PH_TOPIC   = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_BODY    = 3'd6,
		PH_DEAD    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		K_TOPIC   = 3'd0,
		K_PAYLOAD = 3'd1,
		K_CONNACK = 3'd2,
		K_OTHER   = 3'd3,
		K_BAD     = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t item;
	} front_res_t;

	typedef struct packed {
		logic                 empty;
		logic                 full;
		logic [QCNT_W-1:0]    count;
	} queue_stat_t;

endpackage

// ===== rtl/core/mipp_front.sv =====
module mipp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            rx_byte,
	output mipp_pkg::front_res_t  res
);

	mipp_pkg::phase_t                      phase_q, phase_d;
	logic [3:0]                            ptype_q, ptype_d;
	logic [mipp_pkg::LEN_W-1:0]            rlen_q, rlen_d;
	logic [mipp_pkg::GROUP_CNT_W-1:0]      gcnt_q, gcnt_d;
	logic [mipp_pkg::TLEN_W-1:0]           tlen_q, tlen_d;
	logic [mipp_pkg::LEN_W-1:0]            bcnt_q, bcnt_d;

	logic [mipp_pkg::LEN_W-1:0]            bcnt_inc;
	logic [mipp_pkg::LEN_W-1:0]            rlen_acc;
	logic [mipp_pkg::GROUP_CNT_W-1:0]      gcnt_inc;
	logic [4:0]                            grp_shift;
	logic [mipp_pkg::TLEN_W-1:0]           tlen_full;
	logic [mipp_pkg::LEN_W-1:0]            topic_end;
	logic                                  is_known;
	logic                                  len_too_long;
	logic                                  pub_short;
	logic                                  topic_too_long;
	logic                                  topic_last;
	logic                                  pay_last;

	// shared datapath terms
	always_comb begin
		bcnt_inc       = bcnt_q + 1'b1;
		gcnt_inc       = gcnt_q + 1'b1;
		grp_shift      = 5'(gcnt_q[1:0]) * 5'd7;
		rlen_acc       = rlen_q | (mipp_pkg::LEN_W'(rx_byte[6:0]) << grp_shift);
		tlen_full      = {tlen_q[15:8], rx_byte};
		topic_end      = mipp_pkg::LEN_W'(tlen_q) + mipp_pkg::LEN_W'(2);
		is_known       = (rx_byte[7:4] == mipp_pkg::TYPE_PUBLISH)
		              || (rx_byte[7:4] == mipp_pkg::TYPE_CONNACK);
		len_too_long   = rx_byte[7]
		              && (gcnt_inc >= mipp_pkg::GROUP_CNT_W'(mipp_pkg::MAX_LENGTH_GROUPS));
		pub_short      = (ptype_q == mipp_pkg::TYPE_PUBLISH)
		              && (rlen_acc < mipp_pkg::LEN_W'(2));
		topic_too_long = mipp_pkg::LEN_W'(tlen_full) > (rlen_q - mipp_pkg::LEN_W'(2));
		topic_last     = (bcnt_inc == topic_end);
		pay_last       = (bcnt_inc >= rlen_q);
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		ptype_d = ptype_q;
		rlen_d  = rlen_q;
		gcnt_d  = gcnt_q;
		tlen_d  = tlen_q;
		bcnt_d  = bcnt_q;
		if (take) begin
			unique case (phase_q)
				mipp_pkg::PH_HEADER: begin
					ptype_d = rx_byte[7:4];
					rlen_d  = '0;
					gcnt_d  = '0;
					tlen_d  = '0;
					bcnt_d  = '0;
					phase_d = mipp_pkg::PH_LENGTH;
				end
				mipp_pkg::PH_LENGTH: begin
					rlen_d = rlen_acc;
					gcnt_d = gcnt_inc;
					if (rx_byte[7]) begin
						if (len_too_long)
							phase_d = mipp_pkg::PH_DEAD;
					end else begin
						bcnt_d = '0;
						if (ptype_q == mipp_pkg::TYPE_PUBLISH)
							phase_d = pub_short ? mipp_pkg::PH_DEAD : mipp_pkg::PH_TLEN_HI;
						else
							phase_d = (rlen_acc == '0) ? mipp_pkg::PH_HEADER
							                           : mipp_pkg::PH_BODY;
					end
				end
				mipp_pkg::PH_TLEN_HI: begin
					tlen_d  = {rx_byte, 8'h00};
					bcnt_d  = mipp_pkg::LEN_W'(1);
					phase_d = mipp_pkg::PH_TLEN_LO;
				end
				mipp_pkg::PH_TLEN_LO: begin
					tlen_d = tlen_full;
					bcnt_d = mipp_pkg::LEN_W'(2);
					if (topic_too_long)
						phase_d = mipp_pkg::PH_DEAD;
					else if (tlen_full != '0)
						phase_d = mipp_pkg::PH_TOPIC;
					else if (rlen_q == mipp_pkg::LEN_W'(2))
						phase_d = mipp_pkg::PH_HEADER;
					else
						phase_d = mipp_pkg::PH_PAYLOAD;
				end
				mipp_pkg::PH_TOPIC: begin
					bcnt_d = bcnt_inc;
					if (topic_last)
						phase_d = (bcnt_inc == rlen_q) ? mipp_pkg::PH_HEADER
						                               : mipp_pkg::PH_PAYLOAD;
				end
				mipp_pkg::PH_PAYLOAD, mipp_pkg::PH_BODY: begin
					bcnt_d = bcnt_inc;
					if (pay_last)
						phase_d = mipp_pkg::PH_HEADER;
				end
				mipp_pkg::PH_DEAD: begin
					phase_d = mipp_pkg::PH_DEAD;
				end
			endcase
		end
	end

	// result for the byte taken this cycle
	always_comb begin
		res.valid     = 1'b0;
		res.item.kind = mipp_pkg::K_BAD;
		res.item.data = '0;
		res.item.last = 1'b0;
		if (take) begin
			unique case (phase_q)
				mipp_pkg::PH_HEADER: begin
					res.valid     = !is_known;
					res.item.kind = mipp_pkg::K_OTHER;
					res.item.data = {4'h0, rx_byte[7:4]};
				end
				mipp_pkg::PH_LENGTH: begin
					res.valid = rx_byte[7] ? len_too_long : pub_short;
				end
				mipp_pkg::PH_TLEN_LO: begin
					res.valid = topic_too_long;
				end
				mipp_pkg::PH_TOPIC: begin
					res.valid     = 1'b1;
					res.item.kind = mipp_pkg::K_TOPIC;
					res.item.data = rx_byte;
					res.item.last = topic_last;
				end
				mipp_pkg::PH_PAYLOAD: begin
					res.valid     = 1'b1;
					res.item.kind = mipp_pkg::K_PAYLOAD;
					res.item.data = rx_byte;
					res.item.last = pay_last;
				end
				mipp_pkg::PH_BODY: begin
					res.valid     = (ptype_q == mipp_pkg::TYPE_CONNACK)
					             && (bcnt_inc == mipp_pkg::LEN_W'(2));
					res.item.kind = mipp_pkg::K_CONNACK;
					res.item.data = rx_byte;
					res.item.last = 1'b1;
				end
				mipp_pkg::PH_TLEN_HI, mipp_pkg::PH_DEAD: begin
					res.valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mipp_pkg::PH_HEADER;
			ptype_q <= '0;
			rlen_q  <= '0;
			gcnt_q  <= '0;
			tlen_q  <= '0;
			bcnt_q  <= '0;
		end else begin
			phase_q <= phase_d;
			ptype_q <= ptype_d;
			rlen_q  <= rlen_d;
			gcnt_q  <= gcnt_d;
			tlen_q  <= tlen_d;
			bcnt_q  <= bcnt_d;
		end
	end

endmodule

// ===== rtl/core/mipp_queue.sv =====
module mipp_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr,
	input  mipp_pkg::result_t      wr_item,
	input  logic                   rd,
	output mipp_pkg::result_t      rd_item,
	output mipp_pkg::queue_stat_t  stat
);

	mipp_pkg::result_t                 mem_q [mipp_pkg::QUEUE_DEPTH];
	logic [mipp_pkg::QPTR_W-1:0]       wptr_q, rptr_q;
	logic [mipp_pkg::QCNT_W-1:0]       cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == mipp_pkg::QCNT_W'(mipp_pkg::QUEUE_DEPTH));
	assign stat.count = cnt_q;
	assign rd_item    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= wptr_q + 1'b1;
			if (rd)
				rptr_q <= rptr_q + 1'b1;
			unique case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/mipp_back.sv =====
module mipp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  mipp_pkg::result_t  q_item,
	output logic               q_rd,
	input  logic               pop,
	output logic               empty,
	output logic [2:0]         out_kind,
	output logic [7:0]         out_data,
	output logic               out_last
);

	logic               hold_q;
	mipp_pkg::result_t  item_q;

	// refill when the register is free or being drained this cycle
	assign q_rd  = !q_empty && (!hold_q || pop);
	assign empty = !hold_q;

	assign out_kind = item_q.kind;
	assign out_data = item_q.data;
	assign out_last = item_q.last;

	always_ff @(posedge clk) begin
		if (q_rd)
			item_q <= q_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (q_rd) begin
			hold_q <= 1'b1;
		end else if (pop) begin
			hold_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/mqtt_inbound_packet_parser_unit.sv =====
// a result is written into the queue when its byte is transferred, then moves into the registered
// output stage once that stage is free or being popped, and is popped from there
// throughput: one byte per cycle, limited only by the four-entry result queue filling up
// the front parser decides each byte in the cycle of its transfer; the back stage drains the queue
// arst_n low clears the parser to expect a fixed header byte and empties queue and output stage
// after a malformed result the parser stays dead until the next reset
module mqtt_inbound_packet_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  out_kind,
	output logic [7:0]  out_data,
	output logic        out_last
);

	mipp_pkg::front_res_t   front_res;
	mipp_pkg::result_t      q_item;
	mipp_pkg::queue_stat_t  q_stat;
	logic                   take;
	logic                   q_rd;

	// an input transfer is taken only while the queue has a free slot; each byte
	// makes at most one result, so a free slot is all the front ever needs
	assign full = q_stat.full;
	assign take = push && !q_stat.full;

	// front: header, length, topic-length, topic and payload parsing, one byte per cycle while the queue is not full
	mipp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.res     (front_res)
	);

	// short queue decoupling the parser from the result side
	mipp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (front_res.valid),
		.wr_item (front_res.item),
		.rd      (q_rd),
		.rd_item (q_item),
		.stat    (q_stat)
	);

	// back: registered result stage, presented as a queue head to the consumer
	mipp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_stat.empty),
		.q_item   (q_item),
		.q_rd     (q_rd),
		.pop      (pop),
		.empty    (empty),
		.out_kind (out_kind),
		.out_data (out_data),
		.out_last (out_last)
	);

	// the parser never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		front_res.valid |-> !q_stat.full)
		else $error("result written into a full queue");

	// queue occupancy rises on a write that comes without a read
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(front_res.valid && !q_rd) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
		else $error("queue count did not advance on a write");

	// an idle output stage takes a waiting queue entry in the next cycle
	a_back_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !q_stat.empty) |=> !empty)
		else $error("output stage did not pick up a waiting result");

	// other-type and malformed results never carry a last mark
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (out_kind == mipp_pkg::K_OTHER || out_kind == mipp_pkg::K_BAD))
		|-> !out_last)
		else $error("last mark on an other-type or malformed result");

endmodule
